@@ rtl/pgsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics package
// Shared constants, register codes and the types that pass between the front
// part, the item queue and the back part of the accumulator.
// ----------------------------------------------------------------------------
package pgsa_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int FRAME_LIMIT = 65535;

   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int IDX_W  = $clog2(STORE_SIZE);
   localparam int PROD_W = ROW_W + DIM_W;
   localparam int FRM_W  = $clog2(FRAME_LIMIT + 1);

   localparam int PIX_W        = 8;
   localparam int CFG_DIM_W    = 11;
   localparam int GRAD_W       = 9;
   localparam int GIDX_OUT_W   = 20;
   localparam int FRAMES_OUT_W = 16;
   localparam int FRAMES_OUT_MAX = (1 << FRAMES_OUT_W) - 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;

   localparam int MAX_GRAD = 510;
   localparam longint unsigned SUM_LIMIT = longint'(FRAME_LIMIT) * MAX_GRAD;
   localparam longint unsigned SQ_LIMIT  = longint'(FRAME_LIMIT) * MAX_GRAD * MAX_GRAD;
   localparam int SUM_W = $clog2(SUM_LIMIT + 1);
   localparam int SQ_W  = $clog2(SQ_LIMIT + 1);
   localparam int SQR_W = 2 * GRAD_W;

   localparam int LUMA_R     = 77;
   localparam int LUMA_G     = 150;
   localparam int LUMA_B     = 29;
   localparam int LUMA_SHIFT = 8;
   localparam int LUMA_SUM_W = PIX_W + LUMA_SHIFT;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(1024);
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_GRAY_INPUT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] frame_width;
      logic [CFG_DIM_W-1:0] frame_height;
      logic                 gray_input;
   } cfg_type;

   typedef struct packed {
      logic             active;
      logic [IDX_W-1:0] idx;
   } clear_type;

   typedef struct packed {
      logic [PIX_W-1:0]        luma;
      logic                    grad_ok;
      logic [GRAD_W-1:0]       grad;
      logic [IDX_W-1:0]        gidx;
      logic [IDX_W-1:0]        pidx;
      logic                    active;
      logic                    eof;
      logic [FRAMES_OUT_W-1:0] frames_seen;
   } item_type;

endpackage

@@ rtl/pgsa_if.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics channels
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface pgsa_req_if;
   import pgsa_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface pgsa_rsp_if;
   import pgsa_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [PIX_W-1:0]        luma;
   logic                    grad_valid;
   logic [GRAD_W-1:0]       gradient;
   logic [GIDX_OUT_W-1:0]   grad_pixel_index;
   logic                    end_of_frame;
   logic [FRAMES_OUT_W-1:0] frames_seen;
   modport source (output valid, output luma, output grad_valid, output gradient,
                   output grad_pixel_index, output end_of_frame, output frames_seen,
                   input ready);
   modport sink (input valid, input luma, input grad_valid, input gradient,
                 input grad_pixel_index, input end_of_frame, input frames_seen,
                 output ready);
endinterface

interface pgsa_csr_if;
   import pgsa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/pgsa_front.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics front part
// Accepts pixels, tracks the raster position and frame count, converts to
// luma, keeps the two line banks and forms the gradient one row late.
// ----------------------------------------------------------------------------
module pgsa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  pgsa_pkg::cfg_type              cfg,
   input  pgsa_pkg::clear_type            clr,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pgsa_pkg::PIX_W-1:0]     red,
   input  logic [pgsa_pkg::PIX_W-1:0]     green,
   input  logic [pgsa_pkg::PIX_W-1:0]     blue,
   input  logic [pgsa_pkg::QLVL_W-1:0]    queue_level,
   output logic                           push_valid,
   output pgsa_pkg::item_type             push_item
);
   import pgsa_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]        red;
      logic [PIX_W-1:0]        green;
      logic [PIX_W-1:0]        blue;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic [DIM_W-1:0]        w;
      logic                    active;
      logic                    eof;
      logic [FRAMES_OUT_W-1:0] frames_seen;
      logic                    grad_cond;
   } s1_type;

   typedef struct packed {
      logic [PIX_W-1:0]        luma;
      logic [IDX_W-1:0]        pidx;
      logic [IDX_W-1:0]        gidx;
      logic                    grad_ok;
      logic                    active;
      logic                    eof;
      logic [FRAMES_OUT_W-1:0] frames_seen;
      logic                    parity;
   } s2_type;

   function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [FRM_W-1:0]      frame_ff, frame_in, frame_nxt;
   logic                  s1_valid_ff, s2_valid_ff;
   s1_type                s1_ff, s1_in;
   s2_type                s2_ff, s2_in;
   logic [DIM_W-1:0]      w_dim;
   logic [HDIM_W-1:0]     h_dim;
   logic                  accept, last_col, last_row, eof, active;

   logic [LUMA_SUM_W-1:0] luma_sum;
   logic [PIX_W-1:0]      luma;
   logic [PROD_W-1:0]     lin, glin;
   logic                  parity;
   logic [COL_W-1:0]      col_m1, col_p1, addr0, addr1;

   logic [PIX_W-1:0]      bank0_mem [MAX_WIDTH];
   logic [PIX_W-1:0]      bank1_mem [MAX_WIDTH];
   logic [PIX_W-1:0]      bank0_a_ff, bank0_b_ff, bank1_a_ff, bank1_b_ff;
   logic [PIX_W-1:0]      left, right, up;
   logic [GRAD_W-1:0]     grad;

   always_comb begin
      if (cfg.frame_width == '0) begin
         w_dim = DIM_W'(1);
      end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
         w_dim = DIM_W'(MAX_WIDTH);
      end else begin
         w_dim = DIM_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_dim = HDIM_W'(1);
      end else if (int'(cfg.frame_height) > MAX_HEIGHT) begin
         h_dim = HDIM_W'(MAX_HEIGHT);
      end else begin
         h_dim = HDIM_W'(cfg.frame_height);
      end
   end

   assign req_ready = !clr.active &&
                      ((int'(queue_level) + int'(s1_valid_ff) + int'(s2_valid_ff)) < QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign last_col  = (int'(col_ff) + 1) >= int'(w_dim);
   assign last_row  = (int'(row_ff) + 1) >= int'(h_dim);
   assign eof       = last_col && last_row;
   assign active    = int'(frame_ff) < FRAME_LIMIT;
   assign frame_nxt = (eof && active) ? frame_ff + 1'b1 : frame_ff;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      frame_in = frame_ff;
      if (accept) begin
         frame_in = frame_nxt;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_in.red       = red;
      s1_in.green     = green;
      s1_in.blue      = blue;
      s1_in.col       = col_ff;
      s1_in.row       = row_ff;
      s1_in.w         = w_dim;
      s1_in.active    = active;
      s1_in.eof       = eof;
      s1_in.grad_cond = (int'(row_ff) >= 2) && (int'(col_ff) >= 1) &&
                        ((int'(col_ff) + 2) <= int'(w_dim));
      if (int'(frame_nxt) > FRAMES_OUT_MAX) begin
         s1_in.frames_seen = FRAMES_OUT_W'(FRAMES_OUT_MAX);
      end else begin
         s1_in.frames_seen = FRAMES_OUT_W'(frame_nxt);
      end
   end

   always_comb begin
      luma_sum = LUMA_SUM_W'(LUMA_R) * LUMA_SUM_W'(s1_ff.red) +
                 LUMA_SUM_W'(LUMA_G) * LUMA_SUM_W'(s1_ff.green) +
                 LUMA_SUM_W'(LUMA_B) * LUMA_SUM_W'(s1_ff.blue);
      luma     = cfg.gray_input ? s1_ff.red : PIX_W'(luma_sum >> LUMA_SHIFT);
      lin      = PROD_W'(s1_ff.row) * PROD_W'(s1_ff.w) + PROD_W'(s1_ff.col);
      glin     = lin - PROD_W'(s1_ff.w);
      parity   = s1_ff.row[0];
      col_m1   = s1_ff.col - 1'b1;
      col_p1   = s1_ff.col + 1'b1;
      addr0    = parity ? col_m1 : s1_ff.col;
      addr1    = parity ? s1_ff.col : col_m1;
   end

   always_comb begin
      s2_in.luma        = luma;
      s2_in.pidx        = lin[IDX_W-1:0];
      s2_in.gidx        = glin[IDX_W-1:0];
      s2_in.grad_ok     = s1_ff.grad_cond && s1_ff.active;
      s2_in.active      = s1_ff.active;
      s2_in.eof         = s1_ff.eof;
      s2_in.frames_seen = s1_ff.frames_seen;
      s2_in.parity      = parity;
   end

   always_ff @(posedge clock) begin
      if (clr.active) begin
         if (int'(clr.idx) < MAX_WIDTH) begin
            bank0_mem[clr.idx[COL_W-1:0]] <= '0;
            bank1_mem[clr.idx[COL_W-1:0]] <= '0;
         end
      end else if (s1_valid_ff) begin
         if (parity) begin
            bank1_mem[s1_ff.col] <= luma;
         end else begin
            bank0_mem[s1_ff.col] <= luma;
         end
      end
      bank0_a_ff <= bank0_mem[addr0];
      bank0_b_ff <= bank0_mem[col_p1];
      bank1_a_ff <= bank1_mem[addr1];
      bank1_b_ff <= bank1_mem[col_p1];
   end

   always_comb begin
      left  = s2_ff.parity ? bank0_a_ff : bank1_a_ff;
      right = s2_ff.parity ? bank0_b_ff : bank1_b_ff;
      up    = s2_ff.parity ? bank1_a_ff : bank0_a_ff;
      grad  = GRAD_W'(absdiff(right, left)) + GRAD_W'(absdiff(s2_ff.luma, up));
      push_item.luma        = s2_ff.luma;
      push_item.grad_ok     = s2_ff.grad_ok;
      push_item.grad        = s2_ff.grad_ok ? grad : '0;
      push_item.gidx        = s2_ff.grad_ok ? s2_ff.gidx : '0;
      push_item.pidx        = s2_ff.pidx;
      push_item.active      = s2_ff.active;
      push_item.eof         = s2_ff.eof;
      push_item.frames_seen = s2_ff.frames_seen;
   end

   assign push_valid = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         frame_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         frame_ff    <= frame_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

@@ rtl/pgsa_queue.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics item queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module pgsa_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  pgsa_pkg::item_type          push_item,
   input  logic                        pop_ready,
   output logic                        pop_valid,
   output pgsa_pkg::item_type          pop_item,
   output logic [pgsa_pkg::QLVL_W-1:0] level
);
   import pgsa_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]   count_ff, count_in;
   logic                pop;

   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/pgsa_back.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics back part
// Clears the per-pixel stores after reset, then updates maximum luma,
// gradient sum and gradient square sum by read-modify-write and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module pgsa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   input  pgsa_pkg::item_type                pop_item,
   output logic                              pop_ready,
   output pgsa_pkg::clear_type               clr,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pgsa_pkg::PIX_W-1:0]        rsp_luma,
   output logic                              rsp_grad_valid,
   output logic [pgsa_pkg::GRAD_W-1:0]       rsp_gradient,
   output logic [pgsa_pkg::GIDX_OUT_W-1:0]   rsp_grad_pixel_index,
   output logic                              rsp_end_of_frame,
   output logic [pgsa_pkg::FRAMES_OUT_W-1:0] rsp_frames_seen
);
   import pgsa_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]        luma;
      logic                    grad_valid;
      logic [GRAD_W-1:0]       gradient;
      logic [GIDX_OUT_W-1:0]   grad_pixel_index;
      logic                    end_of_frame;
      logic [FRAMES_OUT_W-1:0] frames_seen;
   } rsp_type;

   logic [PIX_W-1:0]  max_mem [STORE_SIZE];
   logic [SUM_W-1:0]  sum_mem [STORE_SIZE];
   logic [SQ_W-1:0]   sq_mem  [STORE_SIZE];

   logic              clr_active_ff, clr_active_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;

   logic              b_valid_ff, b_valid_in;
   item_type          b_item_ff;
   logic [PIX_W-1:0]  max_rd_ff;
   logic [SUM_W-1:0]  sum_rd_ff;
   logic [SQ_W-1:0]   sq_rd_ff;

   logic              fmax_valid_ff, fmax_valid_in;
   logic [IDX_W-1:0]  fmax_addr_ff;
   logic [PIX_W-1:0]  fmax_data_ff;
   logic              fgrad_valid_ff, fgrad_valid_in;
   logic [IDX_W-1:0]  fgrad_addr_ff;
   logic [SUM_W-1:0]  fsum_ff;
   logic [SQ_W-1:0]   fsq_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              b_adv, pop;
   logic [PIX_W-1:0]  cur_max, new_max;
   logic [SUM_W-1:0]  cur_sum, new_sum;
   logic [SQ_W-1:0]   cur_sq, new_sq;
   logic [SQR_W-1:0]  grad_sq;

   assign clr.active = clr_active_ff;
   assign clr.idx    = clr_idx_ff;

   assign b_adv     = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !b_valid_ff || b_adv;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(STORE_SIZE - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      cur_max = (fmax_valid_ff && fmax_addr_ff == b_item_ff.pidx) ? fmax_data_ff : max_rd_ff;
      new_max = (b_item_ff.luma > cur_max) ? b_item_ff.luma : cur_max;
      if (fgrad_valid_ff && fgrad_addr_ff == b_item_ff.gidx) begin
         cur_sum = fsum_ff;
         cur_sq  = fsq_ff;
      end else begin
         cur_sum = sum_rd_ff;
         cur_sq  = sq_rd_ff;
      end
      grad_sq = SQR_W'(b_item_ff.grad) * SQR_W'(b_item_ff.grad);
      new_sum = cur_sum + SUM_W'(b_item_ff.grad);
      new_sq  = cur_sq + SQ_W'(grad_sq);
   end

   always_comb begin
      b_valid_in     = pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      rsp_valid_in   = b_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      fmax_valid_in  = fmax_valid_ff || (b_adv && b_item_ff.active);
      fgrad_valid_in = fgrad_valid_ff || (b_adv && b_item_ff.grad_ok);
      rsp_in         = rsp_ff;
      if (b_adv) begin
         rsp_in.luma             = b_item_ff.luma;
         rsp_in.grad_valid       = b_item_ff.grad_ok;
         rsp_in.gradient         = b_item_ff.grad;
         rsp_in.grad_pixel_index = GIDX_OUT_W'(b_item_ff.gidx);
         rsp_in.end_of_frame     = b_item_ff.eof;
         rsp_in.frames_seen      = b_item_ff.frames_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         max_mem[clr_idx_ff] <= '0;
         sum_mem[clr_idx_ff] <= '0;
         sq_mem[clr_idx_ff]  <= '0;
      end else if (b_adv) begin
         if (b_item_ff.active) begin
            max_mem[b_item_ff.pidx] <= new_max;
         end
         if (b_item_ff.grad_ok) begin
            sum_mem[b_item_ff.gidx] <= new_sum;
            sq_mem[b_item_ff.gidx]  <= new_sq;
         end
      end
      if (pop) begin
         b_item_ff <= pop_item;
         max_rd_ff <= max_mem[pop_item.pidx];
         sum_rd_ff <= sum_mem[pop_item.gidx];
         sq_rd_ff  <= sq_mem[pop_item.gidx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff  <= 1'b1;
         clr_idx_ff     <= '0;
         b_valid_ff     <= 1'b0;
         fmax_valid_ff  <= 1'b0;
         fgrad_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff  <= clr_active_in;
         clr_idx_ff     <= clr_idx_in;
         b_valid_ff     <= b_valid_in;
         fmax_valid_ff  <= fmax_valid_in;
         fgrad_valid_ff <= fgrad_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (b_adv && b_item_ff.active) begin
         fmax_addr_ff <= b_item_ff.pidx;
         fmax_data_ff <= new_max;
      end
      if (b_adv && b_item_ff.grad_ok) begin
         fgrad_addr_ff <= b_item_ff.gidx;
         fsum_ff       <= new_sum;
         fsq_ff        <= new_sq;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_luma             = rsp_ff.luma;
   assign rsp_grad_valid       = rsp_ff.grad_valid;
   assign rsp_gradient         = rsp_ff.gradient;
   assign rsp_grad_pixel_index = rsp_ff.grad_pixel_index;
   assign rsp_end_of_frame     = rsp_ff.end_of_frame;
   assign rsp_frames_seen      = rsp_ff.frames_seen;

endmodule

@@ rtl/pixel_gradient_stats_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics accumulator
// Pixels enter on req_chan in raster order, frame after frame. Each pixel is
// turned into luma, its per-position maximum luma is kept, and the gradient
// magnitude of the pixel one row above is added to per-position sum and
// square-sum stores. One result per pixel leaves on rsp_chan with the luma,
// the gradient just accumulated, its pixel index, an end-of-frame flag and
// the saturated frame count. Registers are written on csr_chan, which is
// always ready; write them only while no pixel is in flight.
// A pixel passes the front stages, the queue, a back read stage and the output
// register. One pixel is taken every cycle while nothing stalls; the back
// part's store read-modify-write sets the rate, forwarding between consecutive
// updates of the same entry. After reset all STORE_SIZE store entries
// (1048576 at the default geometry) are cleared with req_chan.ready low.
// When the receiver stalls, the output register holds its result, the queue
// absorbs the pixels in flight and req_chan.ready drops once it is nearly full.
// ----------------------------------------------------------------------------
module pixel_gradient_stats_accumulator_unit (
   input logic        clock,
   input logic        reset,
   pgsa_req_if.sink   req_chan,
   pgsa_rsp_if.source rsp_chan,
   pgsa_csr_if.sink   csr_chan
);
   import pgsa_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   clear_type         clr;
   logic              push_valid, pop_valid, pop_ready;
   item_type          push_item, pop_item;
   logic [QLVL_W-1:0] queue_level;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_chan.data;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_chan.data;
            CSR_GRAY_INPUT:   cfg_in.gray_input   = csr_chan.data[0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
         cfg_ff.gray_input   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pgsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clr         (clr),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .red         (req_chan.red),
      .green       (req_chan.green),
      .blue        (req_chan.blue),
      .queue_level (queue_level),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   pgsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (queue_level)
   );

   pgsa_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_item             (pop_item),
      .pop_ready            (pop_ready),
      .clr                  (clr),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_luma             (rsp_chan.luma),
      .rsp_grad_valid       (rsp_chan.grad_valid),
      .rsp_gradient         (rsp_chan.gradient),
      .rsp_grad_pixel_index (rsp_chan.grad_pixel_index),
      .rsp_end_of_frame     (rsp_chan.end_of_frame),
      .rsp_frames_seen      (rsp_chan.frames_seen)
   );

endmodule

@@ rtl/pgsa_checker.sv @@
// ----------------------------------------------------------------------------
// Pixel gradient statistics port checker
// Watches the top-level ports for result-channel and reset behavior.
// ----------------------------------------------------------------------------
module pgsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pgsa_pkg::PIX_W-1:0]        rsp_luma,
   input logic                              rsp_grad_valid,
   input logic [pgsa_pkg::GRAD_W-1:0]       rsp_gradient,
   input logic [pgsa_pkg::GIDX_OUT_W-1:0]   rsp_grad_pixel_index,
   input logic                              rsp_end_of_frame,
   input logic [pgsa_pkg::FRAMES_OUT_W-1:0] rsp_frames_seen
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_luma) && $stable(rsp_grad_valid) &&
         $stable(rsp_gradient) && $stable(rsp_grad_pixel_index) &&
         $stable(rsp_end_of_frame) && $stable(rsp_frames_seen))
      else $error("stalled result changed");

   a_no_grad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grad_valid |-> rsp_gradient == '0 && rsp_grad_pixel_index == '0)
      else $error("gradient fields set without an accumulated gradient");

   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("pixels accepted before the store clearing pass");

endmodule

bind pixel_gradient_stats_accumulator_unit pgsa_checker u_pgsa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_luma             (rsp_chan.luma),
   .rsp_grad_valid       (rsp_chan.grad_valid),
   .rsp_gradient         (rsp_chan.gradient),
   .rsp_grad_pixel_index (rsp_chan.grad_pixel_index),
   .rsp_end_of_frame     (rsp_chan.end_of_frame),
   .rsp_frames_seen      (rsp_chan.frames_seen)
);

@@ tb/pgsa_stats_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel gradient statistics result checker
// Watches the pixel, result and register channels of the accumulator. Every
// pixel transfer is run through a local model of the luma conversion, the
// two line buffers and the raster counters, and the outcome waits in order
// until the matching result transfer arrives and is compared field by field.
// ----------------------------------------------------------------------------
module pgsa_stats_checker (
   input  logic        clock,
   input  logic        reset,
   pgsa_req_if         req_mon,
   pgsa_rsp_if         rsp_mon,
   pgsa_csr_if         csr_mon,
   output int unsigned failure_count,
   output int unsigned results_due
);
   import pgsa_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]        luma;
      logic                    grad_valid;
      logic [GRAD_W-1:0]       gradient;
      logic [GIDX_OUT_W-1:0]   grad_pixel_index;
      logic                    end_of_frame;
      logic [FRAMES_OUT_W-1:0] frames_seen;
   } pixel_outcome_type;

   cfg_type           geometry;
   logic [PIX_W-1:0]  line_luma [2*MAX_WIDTH];
   int unsigned       col_pos;
   int unsigned       row_pos;
   int unsigned       frame_total;
   pixel_outcome_type awaited_outcomes [$];

   function automatic int unsigned clamp_dim(int unsigned value, int unsigned limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic pixel_outcome_type compute_luma_grad(logic [PIX_W-1:0] red,
                                                           logic [PIX_W-1:0] green,
                                                           logic [PIX_W-1:0] blue);
      int unsigned       w, h, col, row, luma, left, right, up, grad, gidx;
      int unsigned       slot_cur, slot_prev;
      bit                active, grad_ok, last_col, last_row;
      pixel_outcome_type res;
      w = clamp_dim(32'(geometry.frame_width), MAX_WIDTH);
      h = clamp_dim(32'(geometry.frame_height), MAX_HEIGHT);
      active = frame_total < FRAME_LIMIT;
      slot_cur = (row_pos % 2) * MAX_WIDTH;
      slot_prev = ((row_pos + 1) % 2) * MAX_WIDTH;
      col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      row = (row_pos >= MAX_HEIGHT) ? MAX_HEIGHT - 1 : row_pos;
      if (geometry.gray_input) begin
         luma = 32'(red);
      end else begin
         luma = (LUMA_R * 32'(red) + LUMA_G * 32'(green) + LUMA_B * 32'(blue)) >> LUMA_SHIFT;
      end
      grad_ok = 1'b0;
      grad = 0;
      gidx = 0;
      // The pixel arriving now completes the neighborhood of the one above it.
      if (row >= 2 && col >= 1 && col + 2 <= w) begin
         left = 32'(line_luma[slot_prev + col - 1]);
         right = 32'(line_luma[slot_prev + col + 1]);
         up = 32'(line_luma[slot_cur + col]);
         grad = ((right > left) ? right - left : left - right)
              + ((luma > up) ? luma - up : up - luma);
         gidx = (row - 1) * w + col;
         grad_ok = active && gidx < STORE_SIZE;
      end
      line_luma[slot_cur + col] = PIX_W'(luma);
      if (!grad_ok) begin
         grad = 0;
         gidx = 0;
      end
      last_col = col + 1 >= w;
      last_row = row + 1 >= h;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
      if (last_col && last_row && active) frame_total++;
      res.luma = PIX_W'(luma);
      res.grad_valid = grad_ok;
      res.gradient = GRAD_W'(grad);
      res.grad_pixel_index = GIDX_OUT_W'(gidx);
      res.end_of_frame = last_col && last_row;
      res.frames_seen = (frame_total > FRAMES_OUT_MAX) ? FRAMES_OUT_W'(FRAMES_OUT_MAX)
                                                       : FRAMES_OUT_W'(frame_total);
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
      failure_count++;
   endtask

   always @(posedge clock) begin
      pixel_outcome_type got, want;
      if (reset) begin
         geometry.frame_width = WIDTH_RESET;
         geometry.frame_height = HEIGHT_RESET;
         geometry.gray_input = 1'b0;
         foreach (line_luma[i]) line_luma[i] = '0;
         col_pos = 0;
         row_pos = 0;
         frame_total = 0;
         awaited_outcomes.delete();
         failure_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_FRAME_WIDTH: geometry.frame_width = csr_mon.data;
               CSR_FRAME_HEIGHT: geometry.frame_height = csr_mon.data;
               CSR_GRAY_INPUT: geometry.gray_input = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    compute_luma_grad(req_mon.red, req_mon.green,
                                                      req_mon.blue));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.luma = rsp_mon.luma;
            got.grad_valid = rsp_mon.grad_valid;
            got.gradient = rsp_mon.gradient;
            got.grad_pixel_index = rsp_mon.grad_pixel_index;
            got.end_of_frame = rsp_mon.end_of_frame;
            got.frames_seen = rsp_mon.frames_seen;
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("unrequested result, luma", 32'(got.luma), '0);
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.luma !== want.luma)
                  report_mismatch("luma", 32'(got.luma), 32'(want.luma));
               if (got.grad_valid !== want.grad_valid)
                  report_mismatch("grad_valid", 32'(got.grad_valid), 32'(want.grad_valid));
               if (got.gradient !== want.gradient)
                  report_mismatch("gradient", 32'(got.gradient), 32'(want.gradient));
               if (got.grad_pixel_index !== want.grad_pixel_index)
                  report_mismatch("grad_pixel_index", 32'(got.grad_pixel_index),
                                  32'(want.grad_pixel_index));
               if (got.end_of_frame !== want.end_of_frame)
                  report_mismatch("end_of_frame", 32'(got.end_of_frame),
                                  32'(want.end_of_frame));
               if (got.frames_seen !== want.frames_seen)
                  report_mismatch("frames_seen", 32'(got.frames_seen),
                                  32'(want.frames_seen));
            end
         end
      end
      results_due <= awaited_outcomes.size();
   end

endmodule

@@ tb/tb_pixel_gradient_stats_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel gradient statistics accumulator testbench
// Drives frames of pixels through the accumulator under a series of frame
// geometries and color modes, starting with hand-built frames for the
// extreme gradient, out-of-range sizes and a geometry change in mid-frame,
// then random frames with random stalls on both channels. A checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_pixel_gradient_stats_accumulator_unit;
   import pgsa_pkg::*;

   localparam int          CLOCK_PERIOD  = 12;
   localparam int unsigned LIMIT_CYCLES  = 6_000_000;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          TOTAL_PIXELS  = 850;
   localparam int          CALM_FROM     = 720;

   logic        clock;
   logic        reset;
   int unsigned failure_count;
   int unsigned results_due;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned pixels_sent;

   pgsa_req_if req_chan ();
   pgsa_rsp_if rsp_chan ();
   pgsa_csr_if csr_chan ();

   pixel_gradient_stats_accumulator_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pgsa_stats_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .failure_count (failure_count),
      .results_due   (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("tb_pixel_gradient_stats_accumulator_unit failed");
      $finish;
   end

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                             input logic [PIX_W-1:0] blue);
      int unsigned gap;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 14);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red <= red;
      req_chan.green <= green;
      req_chan.blue <= blue;
      do @(posedge clock); while (!req_chan.ready);
      pixels_sent++;
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Registers change once every result of the previous pixels is back, or once the drain wait gives up.
   task automatic reconfigure(input int unsigned width, input int unsigned height,
                              input bit gray);
      int unsigned spin;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      for (spin = 0; spin < DRAIN_LIMIT && results_due != 0; spin++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_FRAME_WIDTH, CSR_DATA_W'(width));
      write_register(CSR_FRAME_HEIGHT, CSR_DATA_W'(height));
      write_register(CSR_GRAY_INPUT, CSR_DATA_W'(gray));
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [3*PIX_W-1:0] random_rgb();
      logic [PIX_W-1:0] level;
      level = PIX_W'($urandom);
      case ($urandom_range(0, 3))
         0: return {($urandom_range(0, 1) ? 8'hFF : 8'h00),
                    ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                    ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
         1: return {level, level, level};
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic int unsigned random_dim(input int unsigned small_max);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2047);
         1: return $urandom_range(0, 1) ? MAX_WIDTH : 0;
         2: return $urandom_range(MAX_WIDTH + 1, 2047);
         default: return $urandom_range(1, small_max);
      endcase
   endfunction

   initial begin
      int unsigned      width, height, eff_w, eff_h, count;
      bit               gray;
      logic [3*PIX_W-1:0] rgb;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.red <= '0;
      req_chan.green <= '0;
      req_chan.blue <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_FRAME_WIDTH;
      csr_chan.data <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pixels_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A 3x3 color frame whose center sees the largest possible gradient.
      reconfigure(3, 3, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'hFF);

      // Zero sizes act as single-pixel frames; gray mode ignores green and blue.
      reconfigure(0, 0, 1'b1);
      send_pixel(8'hFF, PIX_W'($urandom), PIX_W'($urandom));
      send_pixel(8'h00, PIX_W'($urandom), PIX_W'($urandom));
      send_pixel(8'hAA, 8'hFF, 8'hFF);
      send_pixel(8'h55, 8'h00, 8'h00);

      // Oversized geometry clamps to the maximum; the frame is left unfinished.
      send_idle_pct = 30;
      recv_idle_pct = 30;
      reconfigure(2047, 2047, 1'b1);
      send_pixel(8'h12, 8'h00, 8'h00);
      send_pixel(8'hED, 8'h00, 8'h00);
      send_pixel(8'h80, 8'h00, 8'h00);
      send_pixel(8'h7F, 8'h00, 8'h00);

      // Narrowing the frame in mid-row ends that row; stale rows feed the gradient.
      reconfigure(4, 3, 1'b0);
      repeat (8) begin
         rgb = random_rgb();
         send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
      end

      while (pixels_sent < TOTAL_PIXELS) begin
         width = random_dim(12);
         height = random_dim(8);
         gray = $urandom_range(0, 1);
         eff_w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
         eff_h = (height == 0) ? 1 : ((height > MAX_HEIGHT) ? MAX_HEIGHT : height);
         if (eff_w * eff_h <= 96) begin
            count = eff_w * eff_h * $urandom_range(1, 3) + $urandom_range(0, eff_w);
         end else begin
            count = $urandom_range(8, 48);
         end
         if (count > TOTAL_PIXELS - pixels_sent) begin
            count = TOTAL_PIXELS - pixels_sent;
         end
         if (pixels_sent >= CALM_FROM) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         reconfigure(width, height, gray);
         repeat (count) begin
            rgb = random_rgb();
            send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      for (int spin = 0; spin < DRAIN_LIMIT && results_due != 0; spin++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failure_count == 0 && results_due == 0) begin
         $display("tb_pixel_gradient_stats_accumulator_unit passed");
      end else begin
         $display("tb_pixel_gradient_stats_accumulator_unit failed");
      end
      $finish;
   end

endmodule
